// File: rtl/core/lacc_pkg.sv
// shared types, constants and helpers of the logic analyser capture controller
package lacc_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int COUNT_W     = 17;
    localparam int DATA_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CMP_W       = (COUNT_W > PTR_W) ? COUNT_W : PTR_W;

    typedef enum logic [1:0] {
        OP_RESET   = 2'd0,
        OP_START   = 2'd1,
        OP_OBSERVE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_FREE_RUN   = 2'd0,
        MODE_TRIGGERED  = 2'd1,
        MODE_LINE_CLOCK = 2'd2,
        MODE_UNUSED     = 2'd3
    } mode_t;

    localparam logic [1:0] EDGE_RISING  = 2'd0;
    localparam logic [1:0] EDGE_FALLING = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_CAPTURE = 3'd2;
    localparam logic [2:0] ST_ENDED   = 3'd3;
    localparam logic [2:0] ST_NODATA  = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_WAIT    = 5'b00010,
        PH_CAPTURE = 5'b00100,
        PH_ENDED   = 5'b01000,
        PH_NODATA  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'b01,
        CTL_READ = 2'b10
    } ctl_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_IDLE:    code = ST_IDLE;
            PH_WAIT:    code = ST_WAIT;
            PH_CAPTURE: code = ST_CAPTURE;
            PH_ENDED:   code = ST_ENDED;
            PH_NODATA:  code = ST_NODATA;
            default:    code = ST_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/core/lacc_ram.sv
// generic single-port-write, registered-read ram
module lacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/logic_analyser_capture_control_unit.sv
// top level of the logic analyser capture controller
//
// usage
//   item channel (item_valid / item_stall) carries op, line_level, timer_tick
//   and sample_byte. an item is taken at a clock edge with item_valid high
//   and item_stall low. each item gives exactly one result on the result
//   channel (result_valid / result_stall): status, read_valid, read_data and
//   samples_stored.
//   config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   capture_mode (0), edge_select (1) and sample_count (2); cfg_ready is
//   always high. write config only while no item is in flight.
// timing
//   reset, start and observe items: result registered at the edge that
//   takes the item, one item per cycle while no result waits under
//   result_stall. read items: the result waits for the registered read port
//   of the sample ram; no item is taken while a read is in flight.
// stall
//   while a result waits under result_stall the block takes one more item
//   only once that result leaves; the held result never changes.
// reset
//   rst_n clears phase, pointers, last line level and config registers.
//   the sample ram is not cleared and needs no clearing pass.
module logic_analyser_capture_control_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // item channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [1:0]                         op,
    input  logic                               line_level,
    input  logic                               timer_tick,
    input  logic [lacc_pkg::DATA_W-1:0]        sample_byte,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [2:0]                         status,
    output logic                               read_valid,
    output logic [lacc_pkg::DATA_W-1:0]        read_data,
    output logic [lacc_pkg::COUNT_W-1:0]       samples_stored,
    // config channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lacc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lacc_pkg::COUNT_W-1:0]       cfg_data
);

    import lacc_pkg::*;

    // config registers
    logic [1:0]       mode_reg;
    logic [1:0]       edge_reg;
    logic [PTR_W-1:0] limit_reg;   // sample_count clipped to the store depth
    logic [CMP_W-1:0] count_ext;
    logic             cfg_we;

    // control state
    phase_t           phase_reg, phase_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic             last_reg, last_next;
    ctl_t             ctl_reg, ctl_next;

    // result register
    logic               res_valid_reg;
    logic [2:0]         status_reg;
    logic               rvalid_reg, rvalid_next;
    logic [DATA_W-1:0]  rdata_reg;
    logic [COUNT_W-1:0] stored_reg;

    // decode
    logic        accept;
    logic        is_read;
    logic        edge_hit;
    logic        cap_event;
    logic        mem_we;
    logic        mem_re;
    logic [DATA_W-1:0] mem_q;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign count_ext = CMP_W'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FREE_RUN;
            edge_reg  <= EDGE_RISING;
            limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg <= cfg_data[1:0];
                CFG_EDGE:  edge_reg <= cfg_data[1:0];
                CFG_COUNT:
                begin
                    // clip here so the capture path needs only one compare
                    if (count_ext > CMP_W'(STORE_DEPTH))
                    begin
                        limit_reg <= PTR_W'(STORE_DEPTH);
                    end
                    else
                    begin
                        limit_reg <= PTR_W'(count_ext);
                    end
                end
                default: ;  // index beyond the register list is dropped
            endcase
        end
    end

    // no item is taken while a read waits on the ram; otherwise the output
    // register frees itself in the same edge it is taken
    assign item_stall = (ctl_reg == CTL_READ) || (res_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;
    assign is_read    = (op_t'(op) == OP_READ);

    // edge against the last observed line level; edge codes 2 and 3 count as both
    always_comb
    begin
        if (line_level == last_reg)
        begin
            edge_hit = 1'b0;
        end
        else if (edge_reg == EDGE_RISING)
        begin
            edge_hit = line_level;
        end
        else if (edge_reg == EDGE_FALLING)
        begin
            edge_hit = !line_level;
        end
        else
        begin
            edge_hit = 1'b1;
        end
    end

    assign cap_event = (mode_t'(mode_reg) == MODE_LINE_CLOCK) ? edge_hit : timer_tick;

    always_comb
    begin
        phase_next  = phase_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        last_next   = last_reg;
        rvalid_next = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        unique case (op_t'(op))
            OP_RESET:
            begin
                wp_next    = '0;
                rp_next    = '0;
                phase_next = PH_IDLE;
            end
            OP_START:
            begin
                if (mode_t'(mode_reg) != MODE_UNUSED)
                begin
                    wp_next    = '0;
                    rp_next    = '0;
                    phase_next = (mode_t'(mode_reg) == MODE_FREE_RUN) ? PH_CAPTURE : PH_WAIT;
                end
            end
            OP_OBSERVE:
            begin
                last_next = line_level;
                if (phase_reg == PH_WAIT)
                begin
                    // the trigger item itself stores nothing
                    if (edge_hit)
                    begin
                        phase_next = PH_CAPTURE;
                    end
                end
                else if (phase_reg == PH_CAPTURE && cap_event)
                begin
                    if (wp_reg < limit_reg)
                    begin
                        mem_we  = 1'b1;
                        wp_next = wp_reg + PTR_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_ENDED;
                    end
                end
            end
            OP_READ:
            begin
                // rp never passes wp, so a differing pointer is inside the store
                if (rp_reg == wp_reg)
                begin
                    phase_next = PH_NODATA;
                end
                else
                begin
                    mem_re      = 1'b1;
                    rp_next     = rp_reg + PTR_W'(1);
                    rvalid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign ctl_next = (accept && is_read) ? CTL_READ : CTL_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            last_reg  <= 1'b0;
            ctl_reg   <= CTL_IDLE;
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                wp_reg    <= wp_next;
                rp_reg    <= rp_next;
                last_reg  <= last_next;
            end
        end
    end

    // sample store; writes and reads never meet in one cycle because a read
    // blocks the item channel until its data is back
    lacc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && mem_we),
        .wr_addr (wp_reg[ADDR_W-1:0]),
        .wr_data (sample_byte),
        .rd_en   (accept && mem_re),
        .rd_addr (rp_reg[ADDR_W-1:0]),
        .rd_data (mem_q)
    );

    // result register: loaded at accept, read data merged in the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= !is_read;
        end
        else if (ctl_reg == CTL_READ)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= phase_code(phase_next);
            rvalid_reg <= rvalid_next;
            rdata_reg  <= '0;
            stored_reg <= COUNT_W'(wp_next);
        end
        else if (ctl_reg == CTL_READ)
        begin
            rdata_reg <= rvalid_reg ? mem_q : '0;
        end
    end

    assign result_valid   = res_valid_reg;
    assign status         = status_reg;
    assign read_valid     = rvalid_reg;
    assign read_data      = rdata_reg;
    assign samples_stored = stored_reg;

endmodule

// File: rtl/core/lacc_checker.sv
// port-level checker of the capture controller and its bind
module lacc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           result_valid,
    input logic                           result_stall,
    input logic [2:0]                     status,
    input logic                           read_valid,
    input logic [lacc_pkg::DATA_W-1:0]    read_data,
    input logic [lacc_pkg::COUNT_W-1:0]   samples_stored
);

    import lacc_pkg::*;

    // held result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status)
            && $stable(read_data) && $stable(samples_stored))
        else $error("stalled result changed");

    // no byte without a valid read
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !read_valid |-> read_data == '0)
        else $error("read_data set without read_valid");

    // a returned byte excludes end of data
    a_valid_not_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && read_valid |-> status != ST_NODATA)
        else $error("byte returned with end of data");

    // a returned byte means something was stored
    a_valid_has_samples: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && read_valid |-> samples_stored != '0)
        else $error("byte returned from an empty store");

endmodule

bind logic_analyser_capture_control_unit lacc_checker u_lacc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .status         (status),
    .read_valid     (read_valid),
    .read_data      (read_data),
    .samples_stored (samples_stored)
);

// File: sim/logic_analyser_capture_control_unit_test.sv
// self-checking testbench of the logic analyser capture controller
`timescale 1ns / 100ps

module logic_analyser_capture_control_unit_test;

    import lacc_pkg::*;

    // edge codes the package leaves unnamed
    localparam logic [1:0] EDGE_ANY    = 2'd2;
    localparam logic [1:0] EDGE_SPARE  = 2'd3;
    localparam int         CLK_PERIOD  = 20;
    localparam int         DRAIN_WAIT  = 10;

    typedef struct packed {
        logic [2:0]         status;
        logic               read_valid;
        logic [DATA_W-1:0]  read_data;
        logic [COUNT_W-1:0] samples_stored;
    } capture_result_t;

    // dut ports
    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic [1:0]           op;
    logic                 line_level;
    logic                 timer_tick;
    logic [DATA_W-1:0]    sample_byte;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [2:0]           status;
    logic                 read_valid;
    logic [DATA_W-1:0]    read_data;
    logic [COUNT_W-1:0]   samples_stored;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COUNT_W-1:0]   cfg_data;

    // predicted controller state
    mode_t                cap_mode;
    logic [1:0]           trig_edge;
    logic [COUNT_W-1:0]   target_count;
    logic [2:0]           pred_phase;
    logic [COUNT_W-1:0]   wr_ptr;
    logic [COUNT_W-1:0]   rd_ptr;
    logic                 prev_line;
    logic [DATA_W-1:0]    sample_mem [0:STORE_DEPTH-1];

    capture_result_t      pending_results [$];
    int                   error_count = 0;
    int                   items_sent  = 0;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;

    logic_analyser_capture_control_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .op             (op),
        .line_level     (line_level),
        .timer_tick     (timer_tick),
        .sample_byte    (sample_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .read_valid     (read_valid),
        .read_data      (read_data),
        .samples_stored (samples_stored),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // safety net against a hung handshake
    initial
    begin
        #20_000_000;
        $display("[logic_analyser_capture_control_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction: one result per item, state advanced as the block would
    // ------------------------------------------------------------------
    function automatic capture_result_t predict_capture(input op_t o, input logic line,
                                                        input logic tick,
                                                        input logic [DATA_W-1:0] b);
        capture_result_t r;
        logic            edge_hit;
        logic            event_hit;
        int unsigned     limit;
        r.read_valid = 1'b0;
        r.read_data  = '0;
        case (o)
            OP_RESET:
            begin
                wr_ptr     = '0;
                rd_ptr     = '0;
                pred_phase = ST_IDLE;
            end
            OP_START:
            begin
                // unused mode code leaves everything as it was
                if (cap_mode != MODE_UNUSED)
                begin
                    wr_ptr     = '0;
                    rd_ptr     = '0;
                    pred_phase = (cap_mode == MODE_FREE_RUN) ? ST_CAPTURE : ST_WAIT;
                end
            end
            OP_OBSERVE:
            begin
                // edge is any change against the last observed level,
                // filtered by the edge code; the any and spare codes mean both
                if (line == prev_line)
                    edge_hit = 1'b0;
                else if (trig_edge == EDGE_RISING)
                    edge_hit = line;
                else if (trig_edge == EDGE_FALLING)
                    edge_hit = ~line;
                else
                    edge_hit = 1'b1;
                prev_line = line;
                limit     = (target_count > STORE_DEPTH) ? STORE_DEPTH : target_count;
                event_hit = (cap_mode == MODE_LINE_CLOCK) ? edge_hit : tick;
                if (pred_phase == ST_WAIT)
                begin
                    // the trigger item itself stores nothing
                    if (edge_hit)
                        pred_phase = ST_CAPTURE;
                end
                else if (pred_phase == ST_CAPTURE && event_hit)
                begin
                    if (wr_ptr < limit)
                    begin
                        sample_mem[wr_ptr[ADDR_W-1:0]] = b;
                        wr_ptr = wr_ptr + 1'b1;
                    end
                    else
                        pred_phase = ST_ENDED;
                end
            end
            default:
            begin
                // read meeting the write pointer reports end of data
                if (rd_ptr == wr_ptr)
                    pred_phase = ST_NODATA;
                else if (rd_ptr < STORE_DEPTH)
                begin
                    r.read_data  = sample_mem[rd_ptr[ADDR_W-1:0]];
                    r.read_valid = 1'b1;
                    rd_ptr       = rd_ptr + 1'b1;
                end
            end
        endcase
        r.status         = pred_phase;
        r.samples_stored = wr_ptr;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int exp_val,
                                        input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        capture_result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item waiting: status %0d", status);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("status", exp_r.status, status);
                check_field("read_valid", exp_r.read_valid, read_valid);
                check_field("read_data", exp_r.read_data, read_data);
                check_field("samples_stored", exp_r.samples_stored, samples_stored);
            end
        end
    end

    // receiver back-pressure, changed on the falling edge only
    always @(negedge clk)
        result_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------
    // offer one item, with random idle cycles ahead of it
    task automatic send_item(input op_t o, input logic line, input logic tick,
                             input logic [DATA_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        op          <= o;
        line_level  <= line;
        timer_tick  <= tick;
        sample_byte <= b;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        pending_results.push_back(predict_capture(o, line, tick, b));
        items_sent++;
    endtask

    // sender holds off until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            CFG_MODE:  cap_mode     = mode_t'(data[1:0]);
            CFG_EDGE:  trig_edge    = data[1:0];
            CFG_COUNT: target_count = data;
            default:   ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input mode_t m, input logic [1:0] e, input logic [COUNT_W-1:0] n);
        cfg_write(CFG_MODE, COUNT_W'(m));
        cfg_write(CFG_EDGE, COUNT_W'(e));
        cfg_write(CFG_COUNT, n);
    endtask

    function automatic logic [DATA_W-1:0] any_byte();
        return DATA_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // out of reset: read hits end of data, observe only tracks the line
    task automatic test_idle_after_reset();
        send_item(OP_READ, 1'b0, 1'b0, any_byte());
        send_item(OP_OBSERVE, 1'b1, 1'b1, 8'hFF);
        send_item(OP_RESET, 1'b0, 1'b0, any_byte());
    endtask

    // free running capture on timer ticks, count limit, readback
    task automatic test_async_capture();
        configure(MODE_FREE_RUN, EDGE_RISING, 17'd3);
        send_item(OP_START, 1'b0, 1'b0, any_byte());
        send_item(OP_OBSERVE, 1'b0, 1'b0, 8'h12);
        send_item(OP_OBSERVE, 1'b1, 1'b1, 8'h00);
        send_item(OP_OBSERVE, 1'b0, 1'b1, 8'hFF);
        send_item(OP_OBSERVE, 1'b1, 1'b1, 8'hA5);
        // tick at the limit ends the capture
        send_item(OP_OBSERVE, 1'b0, 1'b1, 8'h5A);
        send_item(OP_OBSERVE, 1'b1, 1'b1, 8'h77);
        repeat (4)
            send_item(OP_READ, 1'b0, 1'b0, any_byte());
        // zero count ends on the first tick
        cfg_write(CFG_COUNT, 17'd0);
        send_item(OP_START, 1'b0, 1'b0, any_byte());
        send_item(OP_OBSERVE, 1'b0, 1'b1, 8'h01);
    endtask

    // waits for a falling edge, trigger item stores nothing, read stops capture
    task automatic test_triggered_capture();
        configure(MODE_TRIGGERED, EDGE_FALLING, 17'd65536);
        send_item(OP_START, 1'b0, 1'b0, any_byte());
        send_item(OP_OBSERVE, 1'b1, 1'b1, 8'h11);
        send_item(OP_OBSERVE, 1'b0, 1'b1, 8'h22);
        // hold the sender until the pipe is empty mid-capture
        drain_results();
        send_item(OP_OBSERVE, 1'b0, 1'b1, 8'h3C);
        send_item(OP_READ, 1'b0, 1'b0, any_byte());
        send_item(OP_READ, 1'b0, 1'b0, any_byte());
        send_item(OP_OBSERVE, 1'b1, 1'b1, 8'h44);
        send_item(OP_RESET, 1'b0, 1'b0, any_byte());
    endtask

    // line edges clock the samples; spare mode and spare edge codes
    task automatic test_sync_capture();
        configure(MODE_LINE_CLOCK, EDGE_ANY, 17'd2);
        send_item(OP_START, 1'b1, 1'b0, any_byte());
        send_item(OP_OBSERVE, 1'b0, 1'b1, 8'h81);
        send_item(OP_OBSERVE, 1'b0, 1'b1, 8'h82);
        send_item(OP_OBSERVE, 1'b1, 1'b0, 8'h83);
        send_item(OP_OBSERVE, 1'b0, 1'b0, 8'h84);
        send_item(OP_OBSERVE, 1'b1, 1'b0, 8'h85);
        cfg_write(CFG_EDGE, COUNT_W'(EDGE_SPARE));
        cfg_write(CFG_MODE, COUNT_W'(MODE_UNUSED));
        send_item(OP_START, 1'b0, 1'b0, any_byte());
        send_item(OP_READ, 1'b0, 1'b0, any_byte());
    endtask

    // random capture sessions: configure, start, observe, read back
    task automatic test_random_sessions(input int n_items);
        int    stop_at;
        int    n_obs;
        int    n_rd;
        int    pick;
        mode_t m;
        logic [COUNT_W-1:0] n;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            m    = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : mode_t'($urandom_range(0, 2));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                n = '0;
            else if (pick == 1)
                n = COUNT_W'($urandom_range(STORE_DEPTH, 2 ** COUNT_W - 1));
            else
                n = COUNT_W'($urandom_range(1, 12));
            configure(m, 2'($urandom_range(0, 3)), n);
            send_item(OP_START, 1'($urandom), 1'($urandom), any_byte());
            n_obs = $urandom_range(4, 30);
            repeat (n_obs)
            begin
                // mostly observe items, now and then a stray item of any kind
                if ($urandom_range(0, 15) == 0)
                    send_item(op_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                              any_byte());
                else
                    send_item(OP_OBSERVE, 1'($urandom), $urandom_range(0, 9) < 6, any_byte());
            end
            n_rd = int'(wr_ptr - rd_ptr) + $urandom_range(0, 2);
            repeat (n_rd)
                send_item(OP_READ, 1'($urandom), 1'($urandom), any_byte());
        end
    endtask

    // count above the store depth is clipped, a short capture keeps running
    task automatic test_large_count();
        configure(MODE_FREE_RUN, EDGE_RISING, 17'h1FFFF);
        send_item(OP_START, 1'b0, 1'b0, any_byte());
        repeat (40)
            send_item(OP_OBSERVE, 1'($urandom), 1'b1, any_byte());
        repeat (41)
            send_item(OP_READ, 1'b0, 1'b0, any_byte());
        send_item(OP_RESET, 1'b0, 1'b0, any_byte());
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        op           = OP_RESET;
        line_level   = 1'b0;
        timer_tick   = 1'b0;
        sample_byte  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_MODE;
        cfg_data     = '0;
        cap_mode     = MODE_FREE_RUN;
        trig_edge    = EDGE_RISING;
        target_count = '0;
        pred_phase   = ST_IDLE;
        wr_ptr       = '0;
        rd_ptr       = '0;
        prev_line    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender idles rarely, receiver stalls often
        tx_idle_pct = 8;
        rx_idle_pct = 68;
        test_idle_after_reset();
        test_async_capture();
        test_triggered_capture();
        test_sync_capture();
        test_random_sessions(400);

        // sender idles often, receiver stalls rarely
        tx_idle_pct = 68;
        rx_idle_pct = 8;
        test_random_sessions(400);

        // back to back at full rate
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_sessions(400);
        test_large_count();

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("[logic_analyser_capture_control_unit] OK");
        else
            $display("[logic_analyser_capture_control_unit] ERROR");
        $finish;
    end

endmodule
